/* rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define BCW_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define BCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also checks across reset
`define BCW_ASSERT_RESET(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bcw_pkg.sv */
// shared types and constants of the bag connectivity witness step unit
package bcw_pkg;

  localparam int SLOTS       = 8;
  localparam int SLOT_W      = 3;
  localparam int TAG_W       = 2;
  localparam int CLOSE_STEPS = $clog2(SLOTS);

  typedef logic [SLOT_W-1:0]                 slot_t;
  typedef logic [SLOTS-1:0]                  mask_t;
  typedef logic [TAG_W-1:0]                  tag_t;
  typedef logic [SLOTS*SLOT_W-1:0]           labels_t;
  // row s holds the set of slots reachable from slot s
  typedef logic [SLOTS-1:0][SLOTS-1:0]       adj_t;

  typedef enum logic [1:0] {
    MODE_ADD_VERTEX = 2'd0,
    MODE_ADD_EDGE   = 2'd1,
    MODE_FORGET     = 2'd2,
    MODE_JOIN       = 2'd3
  } mode_t;

  localparam tag_t TAG_EMPTY  = 2'd0;
  localparam tag_t TAG_LIVE   = 2'd1;
  localparam tag_t TAG_CLOSED = 2'd2;
  localparam tag_t TAG_BROKEN = 2'd3;

  typedef struct packed {
    tag_t  tag;
    mask_t mask;
    logic  bad;
    logic  forget_chk;
    slot_t slot;
    mask_t pres_old;
  } ctl_t;

endpackage

/* rtl/bcw_link_build.sv */
// decodes one transaction into a slot link matrix and side control
module bcw_link_build (
  input  logic [1:0]       mode,
  input  bcw_pkg::slot_t   vertex_a,
  input  bcw_pkg::slot_t   vertex_b,
  input  bcw_pkg::tag_t    tag_in,
  input  bcw_pkg::mask_t   present_in,
  input  bcw_pkg::labels_t labels_in,
  input  bcw_pkg::tag_t    other_tag,
  input  bcw_pkg::mask_t   other_present,
  input  bcw_pkg::labels_t other_labels,
  output bcw_pkg::adj_t    adj,
  output bcw_pkg::ctl_t    ctl
);

  always_comb begin
    bcw_pkg::mode_t md;
    bcw_pkg::slot_t lbl;
    bcw_pkg::tag_t  jtag;
    bcw_pkg::adj_t  m;
    bcw_pkg::ctl_t  c;
    logic           a_in;
    logic           b_in;
    logic           both_empty;

    md = bcw_pkg::mode_t'(mode);
    m  = '0;
    for (int s = 0; s < bcw_pkg::SLOTS; s++) begin
      m[s][s] = 1'b1;
    end
    // links of the first witness, both ends present
    for (int s = 0; s < bcw_pkg::SLOTS; s++) begin
      lbl = labels_in[s*bcw_pkg::SLOT_W +: bcw_pkg::SLOT_W];
      if (present_in[s] && present_in[lbl]) begin
        m[s][lbl] = 1'b1;
        m[lbl][s] = 1'b1;
      end
    end

    a_in       = present_in[vertex_a];
    b_in       = present_in[vertex_b];
    both_empty = (tag_in == bcw_pkg::TAG_EMPTY) && (other_tag == bcw_pkg::TAG_EMPTY);

    if ((tag_in <= bcw_pkg::TAG_LIVE) && (other_tag <= bcw_pkg::TAG_LIVE)) begin
      jtag = bcw_pkg::TAG_LIVE;
    end else if (((tag_in == bcw_pkg::TAG_EMPTY) && (other_tag == bcw_pkg::TAG_CLOSED)) ||
                 ((tag_in == bcw_pkg::TAG_CLOSED) && (other_tag == bcw_pkg::TAG_EMPTY))) begin
      jtag = bcw_pkg::TAG_CLOSED;
    end else begin
      jtag = bcw_pkg::TAG_BROKEN;
    end

    c.tag        = tag_in;
    c.mask       = present_in;
    c.bad        = 1'b0;
    c.forget_chk = 1'b0;
    c.slot       = vertex_a;
    c.pres_old   = present_in;

    unique case (md)
      bcw_pkg::MODE_ADD_VERTEX: begin
        if (a_in) begin
          c.bad = 1'b1;
        end else begin
          c.tag  = tag_in | bcw_pkg::TAG_LIVE;
          c.mask = present_in | (bcw_pkg::mask_t'(1) << vertex_a);
        end
      end
      bcw_pkg::MODE_ADD_EDGE: begin
        if (a_in && b_in) begin
          m[vertex_a][vertex_b] = 1'b1;
          m[vertex_b][vertex_a] = 1'b1;
        end
        c.bad = a_in ^ b_in;
      end
      bcw_pkg::MODE_FORGET: begin
        if (!a_in) begin
          c.bad = 1'b1;
        end else begin
          c.mask       = present_in & ~(bcw_pkg::mask_t'(1) << vertex_a);
          c.forget_chk = (tag_in == bcw_pkg::TAG_LIVE);
        end
      end
      bcw_pkg::MODE_JOIN: begin
        if (both_empty) begin
          c.mask = '0;
          c.tag  = bcw_pkg::TAG_EMPTY;
        end else begin
          c.tag  = jtag;
          c.mask = present_in | other_present;
          // links of the second witness
          for (int s = 0; s < bcw_pkg::SLOTS; s++) begin
            lbl = other_labels[s*bcw_pkg::SLOT_W +: bcw_pkg::SLOT_W];
            if (other_present[s] && other_present[lbl]) begin
              m[s][lbl] = 1'b1;
              m[lbl][s] = 1'b1;
            end
          end
        end
      end
      default: begin
        c.bad = 1'b0;
      end
    endcase

    adj = m;
    ctl = c;
  end

endmodule

/* rtl/bcw_close_stage.sv */
// one boolean squaring step of the reach matrix, registered with valid
module bcw_close_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  bcw_pkg::adj_t adj_in,
  input  bcw_pkg::ctl_t ctl_in,
  output logic          dn_valid,
  input  logic          dn_ready,
  output bcw_pkg::adj_t adj_out,
  output bcw_pkg::ctl_t ctl_out
);

  bcw_pkg::adj_t sq;
  logic          valid_r;
  bcw_pkg::adj_t adj_r;
  bcw_pkg::ctl_t ctl_r;

  // reach within twice the path length; links go both ways, so column j is row j
  always_comb begin
    sq = '0;
    for (int i = 0; i < bcw_pkg::SLOTS; i++) begin
      for (int j = 0; j < bcw_pkg::SLOTS; j++) begin
        sq[i][j] = |(adj_in[i] & adj_in[j]);
      end
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      adj_r <= sq;
      ctl_r <= ctl_in;
    end
  end

  assign dn_valid = valid_r;
  assign adj_out  = adj_r;
  assign ctl_out  = ctl_r;

endmodule

/* rtl/bcw_label_pick.sv */
// canonical labels and final tag from the closed reach matrix
module bcw_label_pick (
  input  bcw_pkg::adj_t    reach,
  input  bcw_pkg::ctl_t    ctl,
  output bcw_pkg::tag_t    tag,
  output bcw_pkg::mask_t   present,
  output bcw_pkg::labels_t labels,
  output logic             accepting,
  output logic             bad
);

  always_comb begin
    bcw_pkg::mask_t   cand;
    bcw_pkg::mask_t   below;
    bcw_pkg::mask_t   root;
    bcw_pkg::slot_t   lbl;
    bcw_pkg::labels_t lab;
    bcw_pkg::tag_t    t;
    logic             multi;
    logic             alone;

    lab  = '0;
    root = '0;
    for (int s = 0; s < bcw_pkg::SLOTS; s++) begin
      // smallest present member of the cell
      cand = reach[s] & ctl.mask;
      lbl  = '0;
      for (int k = bcw_pkg::SLOTS - 1; k >= 0; k--) begin
        if (cand[k]) begin
          lbl = bcw_pkg::slot_t'(k);
        end
      end
      if (ctl.mask[s]) begin
        lab[s*bcw_pkg::SLOT_W +: bcw_pkg::SLOT_W] = lbl;
      end
      // cell roots before the forget
      below   = bcw_pkg::mask_t'((1 << s) - 1);
      root[s] = ctl.pres_old[s] && !(|(reach[s] & ctl.pres_old & below));
    end

    multi = |(root & (root - bcw_pkg::mask_t'(1)));
    alone = !(|(reach[ctl.slot] & ctl.pres_old & ~(bcw_pkg::mask_t'(1) << ctl.slot)));

    t = ctl.tag;
    if (ctl.forget_chk && alone) begin
      t = multi ? bcw_pkg::TAG_BROKEN : bcw_pkg::TAG_CLOSED;
    end

    tag       = t;
    present   = ctl.mask;
    labels    = lab;
    accepting = (t != bcw_pkg::TAG_BROKEN);
    bad       = ctl.bad;
  end

endmodule

/* rtl/bag_connectivity_witness_step_unit.sv */
// an accepted transaction passes the link build register, three reach-matrix squaring
//   stages and the output register before its result shows on the result channel
// throughput: one transaction per cycle while the result channel is not stalled
// every stage holds its item under stall and takes a new one when its slot frees up
// reset: synchronous active-low rst_n clears all stage valids; no clearing pass
module bag_connectivity_witness_step_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_mode,
  input  logic [2:0]             in_vertex_a,
  input  logic [2:0]             in_vertex_b,
  input  logic [1:0]             in_tag_in,
  input  logic [7:0]             in_present_in,
  input  logic [23:0]            in_labels_in,
  input  logic [1:0]             in_other_tag,
  input  logic [7:0]             in_other_present,
  input  logic [23:0]            in_other_labels,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_tag_out,
  output logic [7:0]             out_present_out,
  output logic [23:0]            out_labels_out,
  output logic                   out_accepting,
  output logic                   out_bad_vertex
);

  localparam int STEPS = bcw_pkg::CLOSE_STEPS;

  // link build output, combinational from the input ports
  bcw_pkg::adj_t    lb_adj;
  bcw_pkg::ctl_t    lb_ctl;

  // first register stage: link matrix and control of the transaction
  logic             s1_valid_r;
  bcw_pkg::adj_t    s1_adj_r;
  bcw_pkg::ctl_t    s1_ctl_r;
  logic             s1_ready;

  // squaring chain; index 0 is fed by the first stage
  logic             ch_valid [STEPS+1];
  logic             ch_ready [STEPS+1];
  bcw_pkg::adj_t    ch_adj   [STEPS+1];
  bcw_pkg::ctl_t    ch_ctl   [STEPS+1];

  // label pick, combinational on the closed matrix
  bcw_pkg::tag_t    lp_tag;
  bcw_pkg::mask_t   lp_present;
  bcw_pkg::labels_t lp_labels;
  logic             lp_accepting;
  logic             lp_bad;

  // output register
  logic             out_valid_r;
  bcw_pkg::tag_t    out_tag_r;
  bcw_pkg::mask_t   out_present_r;
  bcw_pkg::labels_t out_labels_r;
  logic             out_accepting_r;
  logic             out_bad_r;
  logic             out_load;

  bcw_link_build u_link_build (
    .mode          (in_mode),
    .vertex_a      (in_vertex_a),
    .vertex_b      (in_vertex_b),
    .tag_in        (in_tag_in),
    .present_in    (in_present_in),
    .labels_in     (in_labels_in),
    .other_tag     (in_other_tag),
    .other_present (in_other_present),
    .other_labels  (in_other_labels),
    .adj           (lb_adj),
    .ctl           (lb_ctl)
  );

  // a stage takes a new transaction when empty or when its content moves on
  assign s1_ready = !s1_valid_r || ch_ready[0];
  assign in_stall = !s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_adj_r <= lb_adj;
      s1_ctl_r <= lb_ctl;
    end
  end

  assign ch_valid[0] = s1_valid_r;
  assign ch_adj[0]   = s1_adj_r;
  assign ch_ctl[0]   = s1_ctl_r;

  // each squaring doubles the covered path length; three reach all slots
  for (genvar g = 0; g < STEPS; g++) begin : g_close
    bcw_close_stage u_close_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (ch_valid[g]),
      .up_ready (ch_ready[g]),
      .adj_in   (ch_adj[g]),
      .ctl_in   (ch_ctl[g]),
      .dn_valid (ch_valid[g+1]),
      .dn_ready (ch_ready[g+1]),
      .adj_out  (ch_adj[g+1]),
      .ctl_out  (ch_ctl[g+1])
    );
  end

  bcw_label_pick u_label_pick (
    .reach     (ch_adj[STEPS]),
    .ctl       (ch_ctl[STEPS]),
    .tag       (lp_tag),
    .present   (lp_present),
    .labels    (lp_labels),
    .accepting (lp_accepting),
    .bad       (lp_bad)
  );

  // output register frees up as soon as the held result is taken
  assign ch_ready[STEPS] = !out_valid_r || !out_stall;
  assign out_load        = ch_valid[STEPS] && ch_ready[STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ch_ready[STEPS]) begin
      out_valid_r <= ch_valid[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tag_r       <= lp_tag;
      out_present_r   <= lp_present;
      out_labels_r    <= lp_labels;
      out_accepting_r <= lp_accepting;
      out_bad_r       <= lp_bad;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_tag_out     = out_tag_r;
  assign out_present_out = out_present_r;
  assign out_labels_out  = out_labels_r;
  assign out_accepting   = out_accepting_r;
  assign out_bad_vertex  = out_bad_r;

endmodule

/* rtl/bcw_checker.sv */
// port-level checker for the step unit and its bind
`include "assert_macros.svh"

module bcw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_tag_out,
  input logic [7:0]  out_present_out,
  input logic [23:0] out_labels_out,
  input logic        out_accepting
);

  `BCW_ASSERT_IMPLY(a_accept_flag, out_valid, out_accepting == (out_tag_out != bcw_pkg::TAG_BROKEN), "accepting flag disagrees with tag")
  `BCW_ASSERT_IMPLY(a_empty_labels, out_valid && (out_present_out == 8'd0), out_labels_out == 24'd0, "labels set on an empty partition")
  `BCW_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable({out_tag_out, out_present_out, out_labels_out}), "stalled result transaction changed")
  `BCW_ASSERT_RESET(a_reset_empty, !rst_n, !out_valid && !in_stall, "pipeline not empty after reset")

endmodule

bind bag_connectivity_witness_step_unit bcw_checker u_bcw_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_tag_out     (out_tag_out),
  .out_present_out (out_present_out),
  .out_labels_out  (out_labels_out),
  .out_accepting   (out_accepting)
);
